@@ sv/tet_pkg.sv @@
// shared types, codes and constants of the timed entry table
// no dependencies

package tet_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_FIELD_TEXT  = 4096;
  localparam int TEXT_LIMIT      = 3 * MAX_FIELD_TEXT;
  localparam int RESULT_CAP      = 64;
  localparam int USEC_PER_MS     = 1000;

  localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd5000000;
  localparam logic [20:0] TEXT_BUDGET_RST     = 21'd262144;
  localparam logic [63:0] ALL_ONES            = '1;

  localparam logic [2:0] REG_DEFAULT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_TEXT_BUDGET     = 3'd4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLOSE  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [2:0] KIND_INSERT_REPLY = 3'd0;
  localparam logic [2:0] KIND_INSERT_ERROR = 3'd1;
  localparam logic [2:0] KIND_CLOSED       = 3'd2;
  localparam logic [2:0] KIND_CLOSE_ACK    = 3'd3;
  localparam logic [2:0] KIND_WAIT_REPLY   = 3'd4;

  localparam logic [1:0] REASON_NONE      = 2'd0;
  localparam logic [1:0] REASON_EXPIRED   = 2'd1;
  localparam logic [1:0] REASON_REQUESTED = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_TEXT     = 2'd2;
  localparam logic [1:0] ERR_EXHAUSED = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] deadline;
    logic        urgent;
    logic [13:0] text_bytes;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [1:0]  reason;
    logic [1:0]  err;
    logic [30:0] wait_ms;
    logic [63:0] revision;
    logic        last;
  } result_t;

endpackage

@@ sv/tet_div.sv @@
// division by one thousand, eleven dividend bits per cycle by reciprocal multiplication
// depends on tet_pkg

module tet_div import tet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quot,
  output logic        rem_nz
);

  // ceil(2^31 / 1000), exact quotient for any 21 bit partial dividend
  localparam logic [42:0] RECIP = 43'd2147484;

  logic        busy;
  logic [2:0]  cnt;
  logic [9:0]  rem;
  logic [65:0] dv;
  logic [63:0] q;
  logic [20:0] v;
  logic [42:0] prod;
  logic [10:0] qd;
  logic [9:0]  rnext;

  assign v      = {rem, dv[65:55]};
  assign prod   = 43'(v) * RECIP;
  assign qd     = prod[41:31];
  assign rnext  = 10'(v - 21'(qd) * 21'(USEC_PER_MS));
  assign quot   = q;
  assign rem_nz = rem != 10'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 3'd5);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= {2'b00, dividend};
      q   <= '0;
    end else if (busy) begin
      rem <= rnext;
      dv  <= {dv[54:0], 11'd0};
      q   <= {q[52:0], qd};
    end
  end

endmodule

@@ sv/timed_entry_table_top.sv @@
// timed entry table: ordered entry memory with insert, close, tick and query
// depends on tet_pkg and tet_div
// flow: accept, each entry scanned in read and check states, each moved in move read and
// write states, result words in emit; insert with allocation rescans per id candidate,
// query waits on the divider. throughput: one item at a time, next word taken once the
// last result is queued. reset: entry count, ids, text total cleared, revision one.

module timed_entry_table_top import tet_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_usec, replace_id, timeout, urgent, text_bytes, target_id, max_wait_ms
  input  logic [207:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_id, close_reason, error_code, wait_ms, revision
  output logic [135:0] m_tdata,
  // kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_RD     = 13'b0000000000010,
    S_CHK    = 13'b0000000000100,
    S_ICHK   = 13'b0000000001000,
    S_COMMIT = 13'b0000000010000,
    S_MV_RD  = 13'b0000000100000,
    S_MV_WR  = 13'b0000001000000,
    S_APPEND = 13'b0000010000000,
    S_EMIT   = 13'b0000100000000,
    S_ACK    = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_QFIN   = 13'b0100000000000,
    S_TEND   = 13'b1000000000000
  } state_t;

  state_t state, ret;

  // configuration
  logic [31:0] default_timeout;
  logic [20:0] text_budget;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= DEFAULT_TIMEOUT_RST;
      text_budget     <= TEXT_BUDGET_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_DEFAULT_TIMEOUT) default_timeout <= pwdata;
      if (paddr == REG_TEXT_BUDGET) text_budget <= pwdata[20:0];
    end
  end

  always_comb begin
    case (paddr)
      REG_DEFAULT_TIMEOUT: prdata = default_timeout;
      REG_TEXT_BUDGET:     prdata = {11'd0, text_budget};
      default:             prdata = '0;
    endcase
  end

  // entry memory
  entry_t          mem [MAX_ENTRIES];
  entry_t          rdata, wdata;
  logic [AW-1:0]   raddr, waddr;
  logic            we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // table state
  logic [CW-1:0] count;
  logic [31:0]   last_issued;
  logic [63:0]   revision;
  logic [20:0]   total;
  logic [63:0]   rev_inc;

  assign rev_inc = (revision + 64'd1 == 64'd0) ? 64'd1 : revision + 64'd1;

  // item registers
  logic [1:0]  op;
  logic [63:0] now;
  logic [31:0] rid, key, cand;
  logic [31:0] tmo;
  logic        urg;
  logic [13:0] bytes;
  logic [31:0] maxw;
  logic [40:0] tmo_mul;
  logic [63:0] deadline;

  // walk registers
  logic [CW-1:0] idx, mv, fidx;
  logic [CW:0]   tries;
  logic          found, alloc;
  logic [13:0]   rem_bytes;
  logic [31:0]   rem_id;
  logic [63:0]   best;
  logic [6:0]    nres;
  logic          pend_valid;
  logic [31:0]   pend_id;
  logic [63:0]   pend_rev;
  result_t       res, outr;

  // divider
  logic        div_start, div_done, div_rem_nz;
  logic [63:0] div_quot;

  tet_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (best - now),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  logic          scan_end, due, out_free;
  logic [CW-1:0] mv_nxt;
  logic [30:0]   maxw_eff;
  logic [20:0]   retained;
  logic [64:0]   dl_sum;
  logic [63:0]   qwait;
  logic [31:0]   cand_nxt;

  assign s_tready = state == S_IDLE;
  assign out_free = !m_tvalid || m_tready;
  assign scan_end = (idx >= count) ||
                    (op == OP_TICK && nres == 7'(RESULT_CAP));
  assign due      = rdata.deadline != 64'd0 && rdata.deadline <= now;
  assign mv_nxt   = mv + CW'(1);
  assign maxw_eff = maxw[31] ? 31'd0 : maxw[30:0];
  assign retained = total - (found ? {7'd0, rem_bytes} : 21'd0);
  assign dl_sum   = tmo[31] ? {1'b0, now} + {33'd0, default_timeout}
                            : {1'b0, now} + {24'd0, tmo_mul};
  assign qwait    = div_quot + {63'd0, div_rem_nz};
  assign cand_nxt = (cand + 32'd1 == 32'd0) ? 32'd1 : cand + 32'd1;

  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_MV_RD) raddr = mv_nxt[AW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = mv[AW-1:0];
    wdata = rdata;
    if (state == S_MV_WR) begin
      we = 1'b1;
    end else if (state == S_APPEND) begin
      we                = 1'b1;
      waddr             = count[AW-1:0];
      wdata.id          = key;
      wdata.deadline    = deadline;
      wdata.urgent      = urg;
      wdata.text_bytes  = bytes;
    end
  end

  assign div_start = state == S_RD && scan_end && op == OP_QUERY &&
                     best != ALL_ONES && best > now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      count       <= '0;
      last_issued <= '0;
      revision    <= 64'd1;
      total       <= '0;
      m_tvalid    <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= s_tuser;
            now        <= s_tdata[63:0];
            rid        <= s_tdata[95:64];
            tmo        <= s_tdata[127:96];
            urg        <= s_tdata[128];
            bytes      <= s_tdata[142:129];
            maxw       <= s_tdata[206:175];
            tmo_mul    <= 41'(s_tdata[126:96]) * 41'(USEC_PER_MS);
            key        <= (s_tuser == OP_CLOSE) ? s_tdata[174:143] : s_tdata[95:64];
            cand       <= (last_issued + 32'd1 == 32'd0) ? 32'd1 : last_issued + 32'd1;
            idx        <= '0;
            found      <= 1'b0;
            alloc      <= 1'b0;
            tries      <= '0;
            best       <= ALL_ONES;
            nres       <= '0;
            pend_valid <= 1'b0;
            if (s_tuser == OP_INSERT && s_tdata[95:64] == 32'd0) state <= S_ICHK;
            else state <= S_RD;
          end
        end
        S_RD: begin
          if (scan_end) begin
            case (op)
              OP_INSERT: state <= alloc ? S_COMMIT : S_ICHK;
              OP_CLOSE:  state <= S_ACK;
              OP_TICK:   state <= S_TEND;
              default: begin
                if (best == ALL_ONES || best <= now) begin
                  res   <= '{KIND_WAIT_REPLY, 32'd0, REASON_NONE, ERR_OK,
                             (best == ALL_ONES) ? maxw_eff : 31'd0, revision, 1'b1};
                  ret   <= S_IDLE;
                  state <= S_EMIT;
                end else begin
                  state <= S_DIV;
                end
              end
            endcase
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          case (op)
            OP_INSERT: begin
              if (alloc && rdata.id == cand) begin
                idx <= '0;
                if (tries + (CW+1)'(1) > {1'b0, count}) begin
                  res   <= '{KIND_INSERT_ERROR, 32'd0, REASON_NONE, ERR_EXHAUSED,
                             31'd0, revision, 1'b1};
                  ret   <= S_IDLE;
                  state <= S_EMIT;
                end else begin
                  tries <= tries + (CW+1)'(1);
                  cand  <= cand_nxt;
                  state <= S_RD;
                end
              end else if (!alloc && rdata.id == key) begin
                found     <= 1'b1;
                fidx      <= idx;
                rem_bytes <= rdata.text_bytes;
                state     <= S_ICHK;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            OP_CLOSE: begin
              if (rdata.id == key) begin
                rem_bytes <= rdata.text_bytes;
                mv        <= idx;
                state     <= S_MV_RD;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            OP_TICK: begin
              if (due) begin
                rem_bytes <= rdata.text_bytes;
                rem_id    <= rdata.id;
                mv        <= idx;
                state     <= S_MV_RD;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            default: begin
              if (rdata.deadline != 64'd0 && rdata.deadline < best) best <= rdata.deadline;
              idx   <= idx + CW'(1);
              state <= S_RD;
            end
          endcase
        end
        S_ICHK: begin
          if (!found && count == CW'(MAX_ENTRIES)) begin
            res   <= '{KIND_INSERT_ERROR, 32'd0, REASON_NONE, ERR_FULL, 31'd0, revision, 1'b1};
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else if ({5'd0, bytes} > 19'(TEXT_LIMIT) || {7'd0, bytes} > text_budget ||
                       retained > text_budget - {7'd0, bytes}) begin
            res   <= '{KIND_INSERT_ERROR, 32'd0, REASON_NONE, ERR_TEXT, 31'd0, revision, 1'b1};
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else if (rid == 32'd0) begin
            alloc <= 1'b1;
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (alloc) key <= cand;
          if (tmo[31] || tmo != 32'd0) deadline <= dl_sum[64] ? ALL_ONES : dl_sum[63:0];
          else deadline <= 64'd0;
          if (found) begin
            mv    <= fidx;
            state <= S_MV_RD;
          end else begin
            state <= S_APPEND;
          end
        end
        S_MV_RD: begin
          if (mv_nxt >= count) begin
            count <= count - CW'(1);
            total <= total - {7'd0, rem_bytes};
            case (op)
              OP_INSERT: state <= S_APPEND;
              OP_CLOSE: begin
                revision <= rev_inc;
                res      <= '{KIND_CLOSED, key, REASON_REQUESTED, ERR_OK, 31'd0, rev_inc, 1'b0};
                ret      <= S_ACK;
                state    <= S_EMIT;
              end
              default: begin
                revision   <= rev_inc;
                nres       <= nres + 7'd1;
                pend_valid <= 1'b1;
                pend_id    <= rem_id;
                pend_rev   <= rev_inc;
                if (pend_valid) begin
                  res   <= '{KIND_CLOSED, pend_id, REASON_EXPIRED, ERR_OK, 31'd0, pend_rev, 1'b0};
                  ret   <= S_RD;
                  state <= S_EMIT;
                end else begin
                  state <= S_RD;
                end
              end
            endcase
          end else begin
            state <= S_MV_WR;
          end
        end
        S_MV_WR: begin
          mv    <= mv_nxt;
          state <= S_MV_RD;
        end
        S_APPEND: begin
          count    <= count + CW'(1);
          total    <= total - (found ? 21'd0 : 21'd0) + {7'd0, bytes};
          revision <= rev_inc;
          if (alloc) last_issued <= key;
          res   <= '{KIND_INSERT_REPLY, key, REASON_NONE, ERR_OK, 31'd0, rev_inc, 1'b1};
          ret   <= S_IDLE;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            outr     <= res;
            m_tvalid <= 1'b1;
            state    <= ret;
          end
        end
        S_ACK: begin
          res   <= '{KIND_CLOSE_ACK, key, REASON_NONE, ERR_OK, 31'd0, revision, 1'b1};
          ret   <= S_IDLE;
          state <= S_EMIT;
        end
        S_DIV: begin
          if (div_done) state <= S_QFIN;
        end
        S_QFIN: begin
          res   <= '{KIND_WAIT_REPLY, 32'd0, REASON_NONE, ERR_OK,
                     (qwait >= {33'd0, maxw_eff}) ? maxw_eff : qwait[30:0], revision, 1'b1};
          ret   <= S_IDLE;
          state <= S_EMIT;
        end
        S_TEND: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
            res   <= '{KIND_CLOSED, pend_id, REASON_EXPIRED, ERR_OK, 31'd0, pend_rev, 1'b1};
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = outr.kind;
  assign m_tlast = outr.last;
  assign m_tdata = {5'd0, outr.revision, outr.wait_ms, outr.err, outr.reason, outr.id};

endmodule
